### src/bfa_pkg.sv
// Shared types, status codes and sizing constants of the best-fit block allocator.
package bfa_pkg;

  localparam int unsigned TABLE_ENTRIES_DEF = 16;
  localparam int unsigned ADDR_BITS_DEF     = 16;
  localparam int unsigned LEN_BITS          = 16;
  localparam logic [LEN_BITS-1:0] POOL_RESET = 16'hFFFF;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_NOFIT    = 3'd1,
    ST_FULL     = 3'd2,
    ST_NOTFOUND = 3'd3,
    ST_ZERO     = 3'd4
  } status_t;

  typedef enum logic {
    KIND_ALLOC = 1'b0,
    KIND_FREE  = 1'b1
  } kind_t;

  typedef struct packed {
    logic        kind;
    logic [15:0] req_size;
    logic [15:0] block_address;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] alloc_address;
  } out_item_t;

  localparam logic [1:0] REG_POOL_SIZE = 2'd0;

endpackage

### src/bfa_cmp.sv
// Shared compare unit: tests one table entry against the current scan goal.
module bfa_cmp #(
  parameter int unsigned ADDR_BITS = bfa_pkg::ADDR_BITS_DEF
) (
  input  logic                     e_valid,
  input  logic                     e_used,
  input  logic [ADDR_BITS-1:0]     e_start,
  input  logic [bfa_pkg::LEN_BITS-1:0] e_len,
  input  logic [ADDR_BITS-1:0]     key_addr,
  input  logic [bfa_pkg::LEN_BITS-1:0] key_len,
  input  logic                     best_found,
  input  logic [ADDR_BITS-1:0]     best_start,
  input  logic [bfa_pkg::LEN_BITS-1:0] best_len,
  output logic                     fits_better,
  output logic                     start_hit,
  output logic                     end_hit,
  output logic                     free_entry
);

  logic [ADDR_BITS:0] e_end;

  always_comb begin
    e_end       = {1'b0, e_start} + (ADDR_BITS+1)'(e_len);
    free_entry  = e_valid && !e_used;
    start_hit   = e_valid && (e_start == key_addr);
    end_hit     = free_entry && (e_end == {1'b0, key_addr});
    fits_better = free_entry && (e_len >= key_len) &&
                  (!best_found || (e_len < best_len) ||
                   ((e_len == best_len) && (e_start < best_start)));
  end

endmodule

### src/best_fit_block_allocator.sv
// Top level of the best-fit block allocator: register table, sequencer and ports.
//
//   channel  direction  handshake        payload
//   in       to block   in_valid/ready   in_item (kind, req_size, block_address)
//   out      from block out_valid/ready  out_item (status, alloc_address)
//   apb      to block   psel/penable     pool_size at address 0
//
// An item is scanned one table entry per cycle through a single compare unit.
// An allocate takes up to two passes (best fit, then spare entry); a free takes
// up to three passes (match, lower neighbor, upper neighbor). A zero-size
// allocate skips the scan and goes straight to its result.
// Reset, or a write of pool_size, leaves one free block covering the pool.
// The result waits in an output register; the next item is taken only after it
// has been delivered, so a stalled output holds the block.
module best_fit_block_allocator #(
  parameter int unsigned TABLE_ENTRIES = bfa_pkg::TABLE_ENTRIES_DEF,
  parameter int unsigned ADDR_BITS     = bfa_pkg::ADDR_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  bfa_pkg::in_item_t in_item,
  output logic              out_valid,
  input  logic              out_ready,
  output bfa_pkg::out_item_t out_item,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  localparam int unsigned IW = $clog2(TABLE_ENTRIES);
  localparam int unsigned LW = bfa_pkg::LEN_BITS;

  typedef enum logic [2:0] {
    S_IDLE, S_BEST, S_SPARE, S_MATCH, S_LOWER, S_UPPER, S_DONE
  } state_t;

  // Entry table. Start/length are plain registers scanned through one mux.
  logic [ADDR_BITS-1:0] e_start [TABLE_ENTRIES];
  logic [LW-1:0]        e_len   [TABLE_ENTRIES];
  logic [TABLE_ENTRIES-1:0] e_used;
  logic [TABLE_ENTRIES-1:0] e_valid;

  logic [LW-1:0] pool_size;
  logic [LW-1:0] pool_next;
  state_t        state;
  logic [IW-1:0] idx;
  logic [LW-1:0] req;
  logic [ADDR_BITS-1:0] key_addr;
  logic          best_found;
  logic [IW-1:0] best;
  logic [ADDR_BITS-1:0] best_start;
  logic [LW-1:0] best_len;
  logic [IW-1:0] cur;

  logic fits_better, start_hit, end_hit, free_entry;
  logic last;
  logic cfg_wr;
  logic [ADDR_BITS-1:0] cmp_addr;

  assign pready   = 1'b1;
  assign cfg_wr   = psel && penable && pwrite && (paddr[2] == bfa_pkg::REG_POOL_SIZE[0]) &&
                    (paddr[1:0] == 2'd0);
  assign prdata   = (paddr[2] == 1'b0) ? {16'd0, pool_size} : 32'd0;
  assign in_ready = (state == S_IDLE);
  assign last     = (idx == IW'(TABLE_ENTRIES-1));
  assign pool_next = rst ? bfa_pkg::POOL_RESET : pwdata[LW-1:0];

  // Upper-neighbor scan looks for a free block starting at the end of the current block.
  assign cmp_addr = (state == S_UPPER) ?
                    ADDR_BITS'({1'b0, e_start[cur]} + (ADDR_BITS+1)'(e_len[cur])) :
                    key_addr;

  bfa_cmp #(.ADDR_BITS(ADDR_BITS)) u_cmp (
    .e_valid    (e_valid[idx]),
    .e_used     (e_used[idx]),
    .e_start    (e_start[idx]),
    .e_len      (e_len[idx]),
    .key_addr   ((state == S_LOWER) ? e_start[cur] : cmp_addr),
    .key_len    (req),
    .best_found (best_found),
    .best_start (best_start),
    .best_len   (best_len),
    .fits_better(fits_better),
    .start_hit  (start_hit),
    .end_hit    (end_hit),
    .free_entry (free_entry)
  );

  logic [ADDR_BITS-1:0] carve_start;
  assign carve_start = ADDR_BITS'({1'b0, best_start} + (ADDR_BITS+1)'(best_len) -
                                  (ADDR_BITS+1)'(req));

  always_ff @(posedge clk) begin
    if (rst || cfg_wr) begin
      // The table collapses to a single free block; an empty pool leaves none.
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
        e_start[i] <= '0;
        e_len[i]   <= (i == 0) ? pool_next : '0;
      end
      e_used    <= '0;
      e_valid   <= TABLE_ENTRIES'(pool_next != '0);
      pool_size <= pool_next;
      if (rst) begin
        state     <= S_IDLE;
        out_valid <= 1'b0;
      end
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            req        <= in_item.req_size;
            key_addr   <= ADDR_BITS'(in_item.block_address);
            idx        <= '0;
            best_found <= 1'b0;
            if (in_item.kind == bfa_pkg::KIND_FREE) begin
              state <= S_MATCH;
            end else if (in_item.req_size == '0) begin
              out_item <= '{status: bfa_pkg::ST_ZERO, alloc_address: '0};
              state    <= S_DONE;
              out_valid <= 1'b1;
            end else begin
              state <= S_BEST;
            end
          end
        end
        S_BEST: begin
          if (fits_better) begin
            best_found <= 1'b1;
            best       <= idx;
            best_start <= e_start[idx];
            best_len   <= e_len[idx];
          end
          if (last) begin
            idx <= '0;
            if (!(best_found || fits_better)) begin
              out_item  <= '{status: bfa_pkg::ST_NOFIT, alloc_address: '0};
              out_valid <= 1'b1;
              state     <= S_DONE;
            end else begin
              state <= S_SPARE;
            end
          end else begin
            idx <= idx + 1'b1;
          end
        end
        S_SPARE: begin
          idx <= idx + 1'b1;
          if (!e_valid[idx]) begin
            e_start[idx] <= carve_start;
            e_len[idx]   <= req;
            e_used[idx]  <= 1'b1;
            e_valid[idx] <= 1'b1;
            e_len[best]  <= best_len - req;
            if (best_len == req) begin
              e_start[best] <= '0;
              e_valid[best] <= 1'b0;
            end
            out_item  <= '{status: bfa_pkg::ST_OK, alloc_address: 16'(carve_start)};
            out_valid <= 1'b1;
            state     <= S_DONE;
          end else if (last) begin
            out_item  <= '{status: bfa_pkg::ST_FULL, alloc_address: '0};
            out_valid <= 1'b1;
            state     <= S_DONE;
          end
        end
        S_MATCH: begin
          if (start_hit) begin
            cur         <= idx;
            e_used[idx] <= 1'b0;
            idx         <= '0;
            state       <= S_LOWER;
          end else begin
            idx <= idx + 1'b1;
            if (last) begin
              out_item  <= '{status: bfa_pkg::ST_NOTFOUND, alloc_address: '0};
              out_valid <= 1'b1;
              state     <= S_DONE;
            end
          end
        end
        S_LOWER: begin
          if (idx != cur && end_hit) begin
            e_len[idx]   <= e_len[idx] + e_len[cur];
            e_start[cur] <= '0;
            e_len[cur]   <= '0;
            e_valid[cur] <= 1'b0;
            cur          <= idx;
            idx          <= '0;
            state        <= S_UPPER;
          end else if (last) begin
            idx   <= '0;
            state <= S_UPPER;
          end else begin
            idx <= idx + 1'b1;
          end
        end
        S_UPPER: begin
          idx <= idx + 1'b1;
          if (idx != cur && free_entry && (e_start[idx] == cmp_addr)) begin
            e_len[cur]   <= e_len[cur] + e_len[idx];
            e_start[idx] <= '0;
            e_len[idx]   <= '0;
            e_valid[idx] <= 1'b0;
            out_item  <= '{status: bfa_pkg::ST_OK, alloc_address: '0};
            out_valid <= 1'b1;
            state     <= S_DONE;
          end else if (last) begin
            out_item  <= '{status: bfa_pkg::ST_OK, alloc_address: '0};
            out_valid <= 1'b1;
            state     <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_ready) begin
            out_valid <= 1'b0;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_out_only_done: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> state == S_DONE) else $error("result shown outside done");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready) else $error("input taken while result pending");
  a_addr_zero_fail: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_item.status != bfa_pkg::ST_OK) |-> out_item.alloc_address == '0)
    else $error("failed item carries an address");
  a_entry0_reset: assert property (@(posedge clk)
    ($past(rst) && !rst) |-> e_valid == TABLE_ENTRIES'(1)) else $error("bad table after reset");
`endif

endmodule
